/* sv/mcst_pkg.sv */
// Shared types and command codes for the multi-channel soft timer.
// No dependencies; used by mcst_eval and multi_channel_soft_timer.
package mcst_pkg;

   localparam int MODE_W = 3;
   localparam int TIME_W = 32;
   localparam int MASK_W = 8;

   localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SET      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ONCE     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PERIODIC = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DISABLE  = 3'd4;

   localparam logic [TIME_W-1:0] NO_DUE = '1;

   // control into the scan evaluation stage
   typedef struct packed {
      logic start;      // clear accumulators before a new pass
      logic valid;      // a channel's RAM data is present this cycle
      logic tick;       // pass belongs to a tick command
      logic active;     // channel active flag
      logic repeat_on;  // channel periodic flag
   } scan_ctl_type;

   // per-channel update coming back from the evaluation stage
   typedef struct packed {
      logic due_we;     // write back advanced due time
      logic drop;       // one-shot channel fired, clear active
   } scan_upd_type;

endpackage

/* sv/mcst_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mcst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

/* sv/mcst_eval.sv */
// Scan evaluation stage: fire decision, due-time advance and earliest-due search.
// Depends on mcst_pkg.
module mcst_eval #(
   parameter int CHANNELS = 8
) (
   input  logic                                         clock,
   input  mcst_pkg::scan_ctl_type                       ctl,
   input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] idx,
   input  logic [mcst_pkg::TIME_W-1:0]                  due_rd,
   input  logic [mcst_pkg::TIME_W-1:0]                  per_rd,
   input  logic [mcst_pkg::TIME_W-1:0]                  now,
   output mcst_pkg::scan_upd_type                       upd,
   output logic [mcst_pkg::TIME_W-1:0]                  due_wdata,
   output logic [mcst_pkg::TIME_W-1:0]                  min_due,
   output logic [CHANNELS-1:0]                          fire_mask
);

   logic [mcst_pkg::TIME_W-1:0] min_ff, min_in;
   logic [CHANNELS-1:0]         fire_ff, fire_in;
   logic                        hit;
   logic                        live;
   logic [mcst_pkg::TIME_W-1:0] eff_due;

   always_comb begin
      hit       = ctl.valid && ctl.tick && ctl.active && (due_rd <= now);
      due_wdata = due_rd + per_rd;
      eff_due   = (hit && ctl.repeat_on) ? due_wdata : due_rd;
      live      = ctl.active && !(hit && !ctl.repeat_on);
      upd.due_we = hit && ctl.repeat_on;
      upd.drop   = hit && !ctl.repeat_on;

      min_in  = min_ff;
      fire_in = fire_ff;
      if (ctl.start) begin
         min_in  = mcst_pkg::NO_DUE;
         fire_in = '0;
      end else if (ctl.valid) begin
         fire_in[idx] = hit;
         if (live && (eff_due < min_ff)) begin
            min_in = eff_due;
         end
      end
   end

   always_ff @(posedge clock) begin
      min_ff  <= min_in;
      fire_ff <= fire_in;
   end

   assign min_due   = min_ff;
   assign fire_mask = fire_ff;

endmodule

/* sv/multi_channel_soft_timer.sv */
// Multi-channel soft timer: due times and periods live in two RAMs, scanned one
// channel per cycle through the RAM read port for every command.
// Start commands (once, periodic) first read the period and write the armed due time
// before the scan. A new command is accepted only in idle, after the previous
// result has been loaded into the output register.
// Reset: time zero, all channels inactive and one-shot, periods read as zero.
module multi_channel_soft_timer #(
   parameter int CHANNELS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_mode,
   input  logic [2:0]                        req_channel,
   input  logic [31:0]                       req_period,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_fire_mask,
   output logic [31:0]                       rsp_nearest_due,
   output logic [31:0]                       rsp_now_ms,
   output logic [7:0]                        rsp_active_mask
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CHANNELS);
   localparam logic [31:0]      CH_LIMIT  = 32'(CHANNELS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ARM  = 3'd1;
   localparam logic [2:0] ST_ARMW = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [2:0]          mode_ff, mode_in;
   logic [IDX_W-1:0]    chan_ff, chan_in;
   logic [31:0]         now_ff, now_in;
   logic [CHANNELS-1:0] active_ff, active_in;
   logic [CHANNELS-1:0] repeat_ff, repeat_in;
   logic [CHANNELS-1:0] pvalid_ff, pvalid_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                proc_vld_ff;
   logic [IDX_W-1:0]    proc_idx_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_fire_ff, rsp_active_ff;
   logic [31:0]         rsp_due_ff, rsp_now_ff;

   logic                accept;
   logic                ch_ok;
   logic [IDX_W+2:0]    ch_ext;
   logic [IDX_W-1:0]    ch_idx;
   logic                issuing;
   logic                slot_free;
   logic                load_rsp;

   logic                per_we;
   logic [31:0]         per_wdata;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [31:0]         per_rd, due_rd, per_eff;
   logic                due_we;
   logic [IDX_W-1:0]    due_waddr;
   logic [31:0]         due_wdata;

   mcst_pkg::scan_ctl_type scan_ctl;
   mcst_pkg::scan_upd_type scan_upd;
   logic [31:0]            eval_wdata;
   logic [31:0]            min_due;
   logic [CHANNELS-1:0]    fire_mask;
   logic [CHANNELS+7:0]    fire_ext, active_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ch_ok     = ({29'd0, req_channel} < CH_LIMIT);
   assign ch_ext    = {IDX_W'(0), req_channel};
   assign ch_idx    = ch_ext[IDX_W-1:0];
   assign issuing   = (state_ff == ST_SCAN) && (cnt_ff != CNT_LIMIT);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == ST_DONE) && slot_free;

   // period store written straight from the request beat
   assign per_we    = accept && (req_mode == mcst_pkg::MODE_SET) && ch_ok;
   assign per_wdata = (req_period == 32'd0) ? 32'd1 : req_period;

   assign rd_en   = issuing || (state_ff == ST_ARM);
   assign rd_addr = (state_ff == ST_ARM) ? chan_ff : cnt_ff[IDX_W-1:0];

   // a never-written period reads as zero
   always_comb begin
      if (state_ff == ST_ARMW) begin
         per_eff = pvalid_ff[chan_ff] ? per_rd : 32'd0;
      end else begin
         per_eff = pvalid_ff[proc_idx_ff] ? per_rd : 32'd0;
      end
   end

   always_comb begin
      if (state_ff == ST_ARMW) begin
         due_we    = 1'b1;
         due_waddr = chan_ff;
         due_wdata = now_ff + per_eff;
      end else begin
         due_we    = scan_upd.due_we;
         due_waddr = proc_idx_ff;
         due_wdata = eval_wdata;
      end
   end

   mcst_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (ch_idx),
      .wr_data (per_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (per_rd)
   );

   mcst_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_due_ram (
      .clock   (clock),
      .wr_en   (due_we),
      .wr_addr (due_waddr),
      .wr_data (due_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (due_rd)
   );

   always_comb begin
      scan_ctl.start     = (state_ff != ST_SCAN) && (state_ff != ST_DONE);
      scan_ctl.valid     = proc_vld_ff;
      scan_ctl.tick      = (mode_ff == mcst_pkg::MODE_TICK);
      scan_ctl.active    = active_ff[proc_idx_ff];
      scan_ctl.repeat_on = repeat_ff[proc_idx_ff];
   end

   mcst_eval #(.CHANNELS(CHANNELS)) u_eval (
      .clock     (clock),
      .ctl       (scan_ctl),
      .idx       (proc_idx_ff),
      .due_rd    (due_rd),
      .per_rd    (per_eff),
      .now       (now_ff),
      .upd       (scan_upd),
      .due_wdata (eval_wdata),
      .min_due   (min_due),
      .fire_mask (fire_mask)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      chan_in      = chan_ff;
      now_in       = now_ff;
      active_in    = active_ff;
      repeat_in    = repeat_ff;
      pvalid_in    = pvalid_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               chan_in  = ch_idx;
               cnt_in   = '0;
               state_in = ST_SCAN;
               if (req_mode == mcst_pkg::MODE_TICK) begin
                  now_in = now_ff + 32'd1;
               end else if (ch_ok) begin
                  case (req_mode) inside
                     mcst_pkg::MODE_SET: begin
                        pvalid_in[ch_idx] = 1'b1;
                     end
                     mcst_pkg::MODE_ONCE, mcst_pkg::MODE_PERIODIC: begin
                        state_in = ST_ARM;
                     end
                     mcst_pkg::MODE_DISABLE: begin
                        active_in[ch_idx] = 1'b0;
                        repeat_in[ch_idx] = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_ARM: begin
            state_in = ST_ARMW;
         end
         ST_ARMW: begin
            active_in[chan_ff] = 1'b1;
            repeat_in[chan_ff] = (mode_ff == mcst_pkg::MODE_PERIODIC);
            state_in           = ST_SCAN;
         end
         ST_SCAN: begin
            if (issuing) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (scan_upd.drop) begin
               active_in[proc_idx_ff] = 1'b0;
            end
            if (!issuing && proc_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         active_ff    <= '0;
         repeat_ff    <= '0;
         pvalid_ff    <= '0;
         cnt_ff       <= '0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         active_ff    <= active_in;
         repeat_ff    <= repeat_in;
         pvalid_ff    <= pvalid_in;
         cnt_ff       <= cnt_in;
         proc_vld_ff  <= issuing;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign fire_ext   = {8'd0, fire_mask};
   assign active_ext = {8'd0, active_ff};

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      chan_ff     <= chan_in;
      proc_idx_ff <= cnt_ff[IDX_W-1:0];
      if (load_rsp) begin
         rsp_fire_ff   <= fire_ext[7:0];
         rsp_due_ff    <= min_due;
         rsp_now_ff    <= now_ff;
         rsp_active_ff <= active_ext[7:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fire_mask   = rsp_fire_ff;
   assign rsp_nearest_due = rsp_due_ff;
   assign rsp_now_ms      = rsp_now_ff;
   assign rsp_active_mask = rsp_active_ff;

   // an accepted beat always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted beat did not leave idle");

   // scan write-back never hits the entry being read in the same cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && due_we && issuing) |-> due_waddr != rd_addr)
      else $error("due RAM write collides with scan read");

   // only ticks fire channels
   a_fire_tick_only: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && mode_ff != mcst_pkg::MODE_TICK) |-> fire_mask == '0)
      else $error("fire mask set on a non-tick command");

   // a result is loaded only when the output slot is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !load_rsp)
      else $error("pending result overwritten");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for multi_channel_soft_timer: queued commands feed a
// bursty driver, and a monitor checks every response beat against a predictor.
// Depends on mcst_pkg for the command codes and on the RTL top level.
`timescale 1ns / 100ps

module tb_top;

   localparam int CHANNELS     = 8;
   localparam int RANDOM_ITEMS = 450;
   localparam int LIMIT_CYCLES = 200000;
   localparam int SETTLE       = CHANNELS + 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT_ITEM = 150;

   // codes past MODE_DISABLE that the block must ignore
   localparam logic [mcst_pkg::MODE_W-1:0] MODE_RSVD_5 = 3'd5;
   localparam logic [mcst_pkg::MODE_W-1:0] MODE_RSVD_6 = 3'd6;
   localparam logic [mcst_pkg::MODE_W-1:0] MODE_RSVD_7 = 3'd7;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  channel;
      logic [31:0] period;
   } timer_cmd_type;

   typedef struct packed {
      logic [7:0]  fire_mask;
      logic [31:0] nearest_due;
      logic [31:0] now_ms;
      logic [7:0]  active_mask;
   } timer_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = '0;
   logic [2:0]  req_channel = '0;
   logic [31:0] req_period = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_fire_mask;
   logic [31:0] rsp_nearest_due;
   logic [31:0] rsp_now_ms;
   logic [7:0]  rsp_active_mask;

   multi_channel_soft_timer #(.CHANNELS(CHANNELS)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_channel     (req_channel),
      .req_period      (req_period),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fire_mask   (rsp_fire_mask),
      .rsp_nearest_due (rsp_nearest_due),
      .rsp_now_ms      (rsp_now_ms),
      .rsp_active_mask (rsp_active_mask)
   );

   always #1 clock = ~clock;

   // predicted timer state
   logic [31:0] now_count;
   logic [31:0] period_store [CHANNELS];
   logic [31:0] next_due     [CHANNELS];
   logic        active_bit   [CHANNELS];
   logic        repeat_on    [CHANNELS];

   timer_cmd_type    cmd_queue[$];
   timer_report_type expected_reports[$];
   int               errors = 0;
   int               cmds_sent = 0;
   int               reports_seen = 0;
   int               fire_events = 0;
   bit               hold_done = 1'b0;
   int               cycle_count = 0;

   function automatic timer_report_type timer_apply(timer_cmd_type cmd);
      timer_report_type rpt;
      logic [31:0]      best;
      int               i;
      rpt = '0;
      if (cmd.mode == mcst_pkg::MODE_TICK) begin
         now_count = now_count + 32'd1;
         for (i = 0; i < CHANNELS; i++) begin
            if (active_bit[i] && next_due[i] <= now_count) begin
               rpt.fire_mask[i] = 1'b1;
               // advance a periodic channel once, even if still late
               if (repeat_on[i]) next_due[i] = next_due[i] + period_store[i];
               else active_bit[i] = 1'b0;
            end
         end
      end else if (cmd.channel < CHANNELS) begin
         case (cmd.mode) inside
            mcst_pkg::MODE_SET: begin
               period_store[cmd.channel] = (cmd.period == '0) ? 32'd1 : cmd.period;
            end
            mcst_pkg::MODE_ONCE, mcst_pkg::MODE_PERIODIC: begin
               repeat_on[cmd.channel]  = (cmd.mode == mcst_pkg::MODE_PERIODIC);
               active_bit[cmd.channel] = 1'b1;
               next_due[cmd.channel]   = now_count + period_store[cmd.channel];
            end
            mcst_pkg::MODE_DISABLE: begin
               active_bit[cmd.channel] = 1'b0;
               repeat_on[cmd.channel]  = 1'b0;
            end
            default: ;
         endcase
      end
      best = mcst_pkg::NO_DUE;
      for (i = 0; i < CHANNELS; i++) begin
         if (active_bit[i] && next_due[i] < best) best = next_due[i];
         if (active_bit[i] && i < mcst_pkg::MASK_W) rpt.active_mask[i] = 1'b1;
      end
      rpt.nearest_due = best;
      rpt.now_ms      = now_count;
      return rpt;
   endfunction

   function automatic logic [31:0] random_period();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return '0;
      if (pick < 50) return $urandom_range(1, 8);
      if (pick < 70) return $urandom_range(9, 40);
      // near the top: due time wraps below the counter
      if (pick < 78) return 32'hFFFF_FFFF - $urandom_range(0, 6);
      return $urandom;
   endfunction

   function automatic timer_cmd_type random_cmd();
      timer_cmd_type cmd;
      int            pick;
      pick        = $urandom_range(0, 99);
      cmd.channel = 3'($urandom_range(0, CHANNELS - 1));
      cmd.period  = $urandom;
      if (pick < 45) cmd.mode = mcst_pkg::MODE_TICK;
      else if (pick < 62) begin
         cmd.mode   = mcst_pkg::MODE_SET;
         cmd.period = random_period();
      end
      else if (pick < 74) cmd.mode = mcst_pkg::MODE_ONCE;
      else if (pick < 86) cmd.mode = mcst_pkg::MODE_PERIODIC;
      else if (pick < 94) cmd.mode = mcst_pkg::MODE_DISABLE;
      else cmd.mode = MODE_RSVD_5 + 3'($urandom_range(0, 2));
      return cmd;
   endfunction

   task automatic push_cmd(input logic [2:0] mode, input logic [2:0] channel,
                           input logic [31:0] period);
      cmd_queue.push_back('{mode: mode, channel: channel, period: period});
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h",
                  $time, name, exp_val, act_val);
      end
   endtask

   // driver: bursts of beats separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      timer_cmd_type nxt;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_reports.push_back(timer_apply(
               '{mode: req_mode, channel: req_channel, period: req_period}));
            cmds_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               nxt = cmd_queue.pop_front();
               req_valid   <= 1'b1;
               req_mode    <= nxt.mode;
               req_channel <= nxt.channel;
               req_period  <= nxt.period;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: style changes every window, plus one long hold-off
   int stall_style = 0;
   int window_left = 0;
   int hold_left   = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && cmds_sent >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (window_left == 0) begin
            window_left = $urandom_range(20, 80);
            stall_style = $urandom_range(0, 3);
         end else begin
            window_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= (window_left % 4 == 0);
            endcase
         end
      end
   end

   // monitor: compare each response beat with the oldest prediction
   always @(posedge clock) begin
      timer_report_type exp_rpt;
      if (!reset && rsp_valid && !rsp_stall) begin
         reports_seen++;
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: response with nothing pending, expected none, actual %h %h %h %h",
                     $time, rsp_fire_mask, rsp_nearest_due, rsp_now_ms,
                     rsp_active_mask);
         end else begin
            exp_rpt = expected_reports.pop_front();
            fire_events += $countones(exp_rpt.fire_mask);
            check_field("fire_mask", {24'd0, exp_rpt.fire_mask}, {24'd0, rsp_fire_mask});
            check_field("nearest_due", exp_rpt.nearest_due, rsp_nearest_due);
            check_field("now_ms", exp_rpt.now_ms, rsp_now_ms);
            check_field("active_mask", {24'd0, exp_rpt.active_mask},
                        {24'd0, rsp_active_mask});
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", LIMIT_CYCLES);
      $display("multi_channel_soft_timer regression: fail");
      $finish;
   end

   initial begin
      int i;
      now_count = '0;
      for (i = 0; i < CHANNELS; i++) begin
         period_store[i] = '0;
         next_due[i]     = '0;
         active_bit[i]   = 1'b0;
         repeat_on[i]    = 1'b0;
      end

      // channel started with no period set: due now, fires on the next tick
      push_cmd(mcst_pkg::MODE_ONCE, 3'd7, 32'hFFFF_FFFF);
      push_cmd(mcst_pkg::MODE_TICK, 3'd0, 32'h0000_0000);
      // zero period stored as one
      push_cmd(mcst_pkg::MODE_SET, 3'd0, 32'h0000_0000);
      push_cmd(mcst_pkg::MODE_PERIODIC, 3'd0, 32'hAAAA_AAAA);
      push_cmd(mcst_pkg::MODE_SET, 3'd1, 32'h0000_0003);
      push_cmd(mcst_pkg::MODE_ONCE, 3'd1, 32'h5555_5555);
      push_cmd(mcst_pkg::MODE_TICK, 3'd1, 32'hFFFF_FFFF);
      push_cmd(mcst_pkg::MODE_TICK, 3'd2, 32'h0000_0000);
      push_cmd(mcst_pkg::MODE_TICK, 3'd3, 32'h1234_5678);
      // due time wraps below now; late periodic keeps firing once per tick
      push_cmd(mcst_pkg::MODE_SET, 3'd2, 32'hFFFF_FFFF);
      push_cmd(mcst_pkg::MODE_PERIODIC, 3'd2, 32'h0000_0000);
      push_cmd(mcst_pkg::MODE_TICK, 3'd0, 32'h0000_0000);
      push_cmd(mcst_pkg::MODE_TICK, 3'd0, 32'h0000_0000);
      push_cmd(mcst_pkg::MODE_DISABLE, 3'd2, 32'hFFFF_FFFF);
      push_cmd(mcst_pkg::MODE_DISABLE, 3'd0, 32'h0000_0000);
      // unknown modes change nothing
      push_cmd(MODE_RSVD_5, 3'd3, 32'h0000_0001);
      push_cmd(MODE_RSVD_6, 3'd4, 32'hFFFF_FFFF);
      push_cmd(MODE_RSVD_7, 3'd7, 32'h0000_0000);
      push_cmd(mcst_pkg::MODE_SET, 3'd6, 32'hAAAA_AAAA);
      push_cmd(mcst_pkg::MODE_SET, 3'd5, 32'h5555_5555);
      push_cmd(mcst_pkg::MODE_PERIODIC, 3'd6, 32'h0000_0000);
      push_cmd(mcst_pkg::MODE_ONCE, 3'd5, 32'h0000_0000);
      push_cmd(mcst_pkg::MODE_TICK, 3'd7, 32'hFFFF_FFFF);
      push_cmd(mcst_pkg::MODE_DISABLE, 3'd6, 32'h0000_0000);
      push_cmd(mcst_pkg::MODE_DISABLE, 3'd5, 32'h0000_0000);
      for (i = 0; i < RANDOM_ITEMS; i++) cmd_queue.push_back(random_cmd());

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("sent %0d commands, checked %0d responses, %0d channel firings",
               cmds_sent, reports_seen, fire_events);
      $display("covered wrap, late periodic, zero period, unknown modes, long hold-off");
      if (errors == 0) begin
         $display("multi_channel_soft_timer regression: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("multi_channel_soft_timer regression: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/mcst_pkg.sv
sv/mcst_ram.sv
sv/mcst_eval.sv
sv/multi_channel_soft_timer.sv
tb/tb_top.sv
